FILE: rtl/acss_pkg.sv
`default_nettype none

package acss_pkg;

  localparam int unsigned ADC_W    = 12;
  localparam int unsigned MV_W     = 12;
  localparam int unsigned SENS_W   = 17;
  localparam int unsigned MA_W     = 30;
  // widest product fed to the divider: |delta| (12 b) * 100000 (17 b)
  localparam int unsigned PROD_W   = 29;
  localparam int unsigned DVS_W    = 17;

  localparam logic [MV_W-1:0]   VREF_MV   = 12'd3300;
  localparam logic [DVS_W-1:0]  ADC_FULL  = 17'd4095;
  localparam logic [SENS_W-1:0] MA_SCALE  = 17'd100000;

  // avg*3300/4095 as (avg*MV_RECIP) >> MV_SH, exact for every 12-bit avg
  localparam int unsigned       MV_SH     = 23;
  localparam logic [MV_SH-1:0]  MV_RECIP  = 23'd6760051;

  localparam logic [MV_W-1:0]   ZERO_OFFSET_RST = 12'd1650;
  localparam logic [SENS_W-1:0] SENS_RST        = 17'd18500;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    logic     cap_avg;
    logic     cap_mv;
    logic     mul_ma;
    logic     cap_ma;
    logic     out_load;
  } acss_cmd_t;

  typedef struct packed {
    logic last_sample;
    logic div_done;
    logic mode_cal;
  } acss_status_t;

endpackage

`default_nettype wire

FILE: rtl/acss_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module acss_div
  import acss_pkg::*;
#(
  parameter int unsigned DIV_W = 29
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic      [DIV_W-1:0] quotient_o,
  output logic                  done_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] dq_q, dq_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_q, dq_q[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
  end

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DIV_W);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      dq_d  = {dq_q[DIV_W-2:0], fits};
      rem_d = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = dq_q;
  assign done_o     = done_q;

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (busy_q && !done_q && cnt_q == CNT_W'(DIV_W)))
    else $error("divider did not start");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

endmodule

`default_nettype wire

FILE: rtl/acss_datapath.sv
`default_nettype none

module acss_datapath
  import acss_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_WINDOW = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire acss_cmd_t               cmd_i,
  output acss_status_t                 status_o,
  input  wire logic [ADC_W-1:0]        sample_i,
  input  wire logic                    op_i,
  input  wire logic [MV_W-1:0]         zero_offset_mv_i,
  input  wire logic [SENS_W-1:0]       sensitivity_i,
  output logic      [ADC_W-1:0]        raw_average_o,
  output logic      [MV_W-1:0]         output_mv_o,
  output logic signed [MA_W-1:0]       current_ma_o,
  output logic                         was_calibration_o,
  output logic      [MV_W-1:0]         offset_in_use_mv_o
);

  localparam int unsigned CNT_W = (SAMPLES_PER_WINDOW > 1) ? $clog2(SAMPLES_PER_WINDOW) : 1;
  localparam int unsigned SUM_W = ADC_W + $clog2(SAMPLES_PER_WINDOW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_WINDOW - 1);
  // mean as a reciprocal multiply; shift chosen so the floor is exact for any full window
  localparam int unsigned AVG_SH = $clog2(SAMPLES_PER_WINDOW * SAMPLES_PER_WINDOW *
                                          ((1 << ADC_W) - 1) + 1);
  localparam int unsigned RCP_W  = AVG_SH + 1;
  localparam logic [RCP_W-1:0] AVG_RECIP = RCP_W'(((64'd1 << AVG_SH) +
      64'(SAMPLES_PER_WINDOW) - 64'd1) / 64'(SAMPLES_PER_WINDOW));
  localparam int unsigned AVG_PROD_W = SUM_W + RCP_W;
  localparam int unsigned MV_PROD_W  = ADC_W + MV_SH;

  logic [SUM_W-1:0]       sum_q, sum_nxt;
  logic [CNT_W-1:0]       cnt_q;
  logic                   mode_q;
  logic [ADC_W-1:0]       avg_q;
  logic [MV_W-1:0]        mv_q;
  logic [PROD_W-1:0]      prod_q;
  logic [MV_W-1:0]        mag_q;
  logic                   neg_q;
  logic signed [MA_W-1:0] ma_q;
  logic [MV_W-1:0]        cal_off_q;
  logic                   cal_valid_q;

  logic [MV_W-1:0]        off_use;
  logic [AVG_PROD_W-1:0]  avg_prod;
  logic [ADC_W-1:0]       avg_calc;
  logic [MV_PROD_W-1:0]   mv_prod;
  logic [MV_W-1:0]        mv_calc;
  logic [MA_W-1:0]        ma_mag;
  logic [DVS_W-1:0]       div_divisor;
  logic [PROD_W-1:0]      div_q;
  logic                   div_done;

  always_comb begin
    sum_nxt  = ((cnt_q == '0) ? '0 : sum_q) + SUM_W'(sample_i);
    off_use  = cal_valid_q ? cal_off_q : zero_offset_mv_i;
    avg_prod = AVG_PROD_W'(sum_q) * AVG_PROD_W'(AVG_RECIP);
    avg_calc = avg_prod[AVG_SH +: ADC_W];
    mv_prod  = MV_PROD_W'(avg_q) * MV_PROD_W'(MV_RECIP);
    mv_calc  = mv_prod[MV_SH +: MV_W];
    ma_mag   = MA_W'(div_q);
    // a zero sensitivity acts as one
    div_divisor = (sensitivity_i == '0) ? DVS_W'(1) : sensitivity_i;
  end

  acss_div #(
    .DIV_W(PROD_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(prod_q),
    .divisor_i (div_divisor),
    .quotient_o(div_q),
    .done_o    (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      mode_q      <= 1'b0;
      cal_valid_q <= 1'b0;
      cal_off_q   <= '0;
    end else begin
      if (cmd_i.accept) begin
        if (cnt_q == '0) begin
          mode_q <= op_i;
        end
        cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + CNT_W'(1);
      end
      if (cmd_i.out_load && mode_q) begin
        cal_off_q   <= mv_q;
        cal_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sum_q <= sum_nxt;
    end
    if (cmd_i.cap_avg) begin
      avg_q <= avg_calc;
    end
    if (cmd_i.cap_mv) begin
      mv_q  <= mv_calc;
      neg_q <= (mv_calc < off_use);
      mag_q <= (mv_calc < off_use) ? (off_use - mv_calc) : (mv_calc - off_use);
    end
    if (cmd_i.mul_ma) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(MA_SCALE);
    end
    if (cmd_i.cap_ma) begin
      ma_q <= neg_q ? -$signed(ma_mag) : $signed(ma_mag);
    end
    if (cmd_i.out_load) begin
      raw_average_o      <= avg_q;
      output_mv_o        <= mv_q;
      current_ma_o       <= mode_q ? '0 : ma_q;
      was_calibration_o  <= mode_q;
      offset_in_use_mv_o <= mode_q ? mv_q : off_use;
    end
  end

  assign status_o.last_sample = (cnt_q == CNT_LAST);
  assign status_o.div_done    = div_done;
  assign status_o.mode_cal    = mode_q;

  a_cal_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && mode_q) |=> (cal_valid_q && cal_off_q == $past(mv_q)))
    else $error("calibration offset not stored");

endmodule

`default_nettype wire

FILE: rtl/acss_ctrl.sv
`default_nettype none

module acss_ctrl
  import acss_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  input  wire acss_status_t status_i,
  output acss_cmd_t         cmd_o
);

  typedef enum logic [6:0] {
    S_ACC      = 7'b000_0001,
    S_AVG      = 7'b000_0010,
    S_MV       = 7'b000_0100,
    S_MUL_MA   = 7'b000_1000,
    S_MA_START = 7'b001_0000,
    S_DIV_MA   = 7'b010_0000,
    S_OUT      = 7'b100_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    out_valid_d   = out_valid_q && out_stall_i;
    unique case (state_q)
      S_ACC: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.last_sample) begin
          state_d = S_AVG;
        end
      end
      S_AVG: begin
        cmd_o.cap_avg = 1'b1;
        state_d       = S_MV;
      end
      S_MV: begin
        cmd_o.cap_mv = 1'b1;
        // a calibrate window has no current to work out
        state_d      = status_i.mode_cal ? S_OUT : S_MUL_MA;
      end
      S_MUL_MA: begin
        cmd_o.mul_ma = 1'b1;
        state_d      = S_MA_START;
      end
      S_MA_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_MA;
      end
      S_DIV_MA: begin
        if (status_i.div_done) begin
          cmd_o.cap_ma = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_ACC);
  assign out_valid_o = out_valid_q;

  a_last_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && in_valid_i && status_i.last_sample) |=> (state_q == S_AVG))
    else $error("window end did not start averaging");

  a_out_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i) |=> (state_q == S_OUT && out_valid_q))
    else $error("result overwrote a pending request");

endmodule

`default_nettype wire

FILE: rtl/averaged_current_sensor_scaler_top.sv
// Samples are taken one per cycle while accumulating; the last sample of a window starts
// the arithmetic: for a measure window the mean, mV, product, then a 29-step
// one-bit-per-cycle divide by the sensitivity; for a calibrate window the mean and mV.
// Samples are stalled meanwhile and for as long as a finished result waits on out_stall_i.
// Reset (asynchronous, active low) clears the window, the calibration and the registers
// (zero offset 1650 mV, sensitivity 18500); no clearing pass.
`default_nettype none

module averaged_current_sensor_scaler_top
  import acss_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_WINDOW = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ADC_W-1:0]    sample_i,
  input  wire logic                op_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [ADC_W-1:0]    raw_average_o,
  output logic      [MV_W-1:0]     output_mv_o,
  output logic signed [MA_W-1:0]   current_ma_o,
  output logic                     was_calibration_o,
  output logic      [MV_W-1:0]     offset_in_use_mv_o
);

  typedef enum logic [0:0] {
    REG_ZERO_OFFSET = 1'b0,
    REG_SENSITIVITY = 1'b1
  } reg_idx_e;

  logic [MV_W-1:0]   zero_offset_q;
  logic [SENS_W-1:0] sens_q;
  reg_idx_e          reg_idx;
  logic              wr_en;

  acss_cmd_t         cmd;
  acss_status_t      status;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_offset_q <= ZERO_OFFSET_RST;
      sens_q        <= SENS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ZERO_OFFSET: zero_offset_q <= pwdata[MV_W-1:0];
        REG_SENSITIVITY: sens_q        <= pwdata[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ZERO_OFFSET: prdata = 32'(zero_offset_q);
      REG_SENSITIVITY: prdata = 32'(sens_q);
      default:         prdata = '0;
    endcase
  end

  acss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  acss_datapath #(
    .SAMPLES_PER_WINDOW(SAMPLES_PER_WINDOW)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .sample_i          (sample_i),
    .op_i              (op_i),
    .zero_offset_mv_i  (zero_offset_q),
    .sensitivity_i     (sens_q),
    .raw_average_o     (raw_average_o),
    .output_mv_o       (output_mv_o),
    .current_ma_o      (current_ma_o),
    .was_calibration_o (was_calibration_o),
    .offset_in_use_mv_o(offset_in_use_mv_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/averaged_current_sensor_scaler_top_test.sv
module averaged_current_sensor_scaler_top_test;
  import acss_pkg::*;

  localparam int unsigned SAMPLES_PER_WINDOW = 16;
  localparam int unsigned CYCLE_LIMIT        = 400000;
  localparam int unsigned SETTLE_CYCLES      = 120;
  localparam int unsigned IDLE_PCT           = 30;
  localparam int unsigned REPORT_MAX         = 10;

  localparam logic       OP_MEASURE      = 1'b0;
  localparam logic       OP_CALIBRATE    = 1'b1;
  localparam logic [2:0] REG_ZERO_OFFSET = 3'd0;
  localparam logic [2:0] REG_SENSITIVITY = 3'd4;

  typedef struct packed {
    logic [ADC_W-1:0] sample;
    logic             op;
  } adc_req_t;

  typedef struct packed {
    logic [ADC_W-1:0]        raw_average;
    logic [MV_W-1:0]         output_mv;
    logic signed [MA_W-1:0]  current_ma;
    logic                    was_calibration;
    logic [MV_W-1:0]         offset_mv;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ADC_W-1:0]  sample_i = '0;
  logic              op_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ADC_W-1:0]  raw_average_o;
  logic [MV_W-1:0]   output_mv_o;
  logic signed [MA_W-1:0] current_ma_o;
  logic              was_calibration_o;
  logic [MV_W-1:0]   offset_in_use_mv_o;

  averaged_current_sensor_scaler_top #(
    .SAMPLES_PER_WINDOW(SAMPLES_PER_WINDOW)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .op_i              (op_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .raw_average_o     (raw_average_o),
    .output_mv_o       (output_mv_o),
    .current_ma_o      (current_ma_o),
    .was_calibration_o (was_calibration_o),
    .offset_in_use_mv_o(offset_in_use_mv_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  adc_req_t adc_stream[$];
  reading_t expected_readings[$];

  // scaler state as seen from outside
  logic [MV_W-1:0]   cfg_zero_mv = ZERO_OFFSET_RST;
  logic [SENS_W-1:0] cfg_sens    = SENS_RST;
  int unsigned       win_sum = 0;
  int unsigned       win_count = 0;
  logic              win_cal = 1'b0;
  logic [MV_W-1:0]   cal_offset_mv = '0;
  logic              cal_valid = 1'b0;

  // window shaping for generated samples
  int unsigned gen_pos = 0;
  int          gen_base = 0;
  int          gen_spread = 0;

  logic        no_gaps = 1'b0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned samples_taken = 0;
  int unsigned measure_seen = 0;
  int unsigned calib_seen = 0;
  int unsigned reg_writes = 0;

  task automatic fold_sample(input adc_req_t req);
    logic [ADC_W-1:0] avg;
    longint           mv;
    longint           offs;
    longint           sens;
    longint           ma;
    reading_t         r;
    if (win_count == 0) begin
      win_cal = (req.op == OP_CALIBRATE);
      win_sum = 0;
    end
    win_sum   += req.sample;
    win_count += 1;
    if (win_count == SAMPLES_PER_WINDOW) begin
      win_count = 0;
      avg = ADC_W'(win_sum / SAMPLES_PER_WINDOW);
      mv  = longint'(avg) * longint'(VREF_MV) / longint'(ADC_FULL);
      ma  = 0;
      if (win_cal) begin
        cal_offset_mv = mv[MV_W-1:0];
        cal_valid     = 1'b1;
      end else begin
        offs = cal_valid ? longint'(cal_offset_mv) : longint'(cfg_zero_mv);
        sens = (cfg_sens == '0) ? 1 : longint'(cfg_sens);
        ma   = ((mv - offs) * longint'(MA_SCALE)) / sens;
      end
      r.raw_average     = avg;
      r.output_mv       = mv[MV_W-1:0];
      r.current_ma      = ma[MA_W-1:0];
      r.was_calibration = win_cal;
      r.offset_mv       = cal_valid ? cal_offset_mv : cfg_zero_mv;
      expected_readings.push_back(r);
    end
  endtask

  task automatic push_sample(input int unsigned smp, input logic op);
    adc_req_t req;
    req.sample = smp[ADC_W-1:0];
    req.op     = op;
    adc_stream.push_back(req);
    gen_pos = (gen_pos + 1) % SAMPLES_PER_WINDOW;
  endtask

  // each window gets a base level and a spread so averages cover the whole range
  task automatic queue_samples(input int count, input int unsigned cal_pct);
    int   s;
    logic op;
    for (int k = 0; k < count; k++) begin
      if (gen_pos == 0) begin
        case ($urandom_range(0, 9))
          0: begin
            gen_base   = $urandom_range(0, 1) * 4095;
            gen_spread = 0;
          end
          1, 2: begin
            gen_base   = 2048;
            gen_spread = 2048;
          end
          default: begin
            gen_base   = $urandom_range(0, 4095);
            gen_spread = $urandom_range(0, 64);
          end
        endcase
        op = ($urandom_range(0, 99) < cal_pct) ? OP_CALIBRATE : OP_MEASURE;
      end else begin
        op = logic'($urandom_range(0, 1));
      end
      s = gen_base + int'($urandom_range(0, 2 * gen_spread)) - gen_spread;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      push_sample(s, op);
    end
  endtask

  task automatic reg_write(input logic [2:0] addr, input int unsigned value);
    logic [31:0] data;
    data = $urandom();
    if (addr == REG_ZERO_OFFSET) data[MV_W-1:0] = value[MV_W-1:0];
    else data[SENS_W-1:0] = value[SENS_W-1:0];
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_ZERO_OFFSET) cfg_zero_mv = data[MV_W-1:0];
    else cfg_sens = data[SENS_W-1:0];
    reg_writes++;
  endtask

  task automatic drain();
    while (adc_stream.size() != 0 || in_valid_i || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned zero_mv, input int unsigned sens,
                           input int count, input int unsigned cal_pct);
    reg_write(REG_ZERO_OFFSET, zero_mv);
    reg_write(REG_SENSITIVITY, sens);
    queue_samples(count, cal_pct);
    drain();
  endtask

  function automatic int unsigned pick_sens();
    case ($urandom_range(0, 5))
      0:       return 1;
      1:       return 100000;
      2:       return 131071;
      default: return $urandom_range(1, 100000);
    endcase
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        fold_sample({sample_i, op_i});
        samples_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (adc_stream.size() != 0 && (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid_i <= 1'b1;
          sample_i   <= adc_stream[0].sample;
          op_i       <= adc_stream[0].op;
          void'(adc_stream.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // reading monitor
  always @(posedge clk_i) begin
    reading_t got;
    reading_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {raw_average_o, output_mv_o, current_ma_o, was_calibration_o,
               offset_in_use_mv_o};
        if (was_calibration_o) calib_seen++;
        else measure_seen++;
        if (expected_readings.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("unexpected reading: avg=%0d mv=%0d ma=%0d cal=%0b off=%0d",
                     got.raw_average, got.output_mv, got.current_ma,
                     got.was_calibration, got.offset_mv);
        end else begin
          want = expected_readings.pop_front();
          if (got.raw_average != want.raw_average || got.output_mv != want.output_mv ||
              got.current_ma != want.current_ma ||
              got.was_calibration != want.was_calibration ||
              got.offset_mv != want.offset_mv) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("reading differs: exp avg=%0d mv=%0d ma=%0d cal=%0b off=%0d | got avg=%0d mv=%0d ma=%0d cal=%0b off=%0d",
                       want.raw_average, want.output_mv, want.current_ma,
                       want.was_calibration, want.offset_mv,
                       got.raw_average, got.output_mv, got.current_ma,
                       got.was_calibration, got.offset_mv);
          end
        end
      end
      out_stall_i <= !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: full-scale measure window, then an all-zero one;
    // ops after the first sample must be ignored
    for (int k = 0; k < SAMPLES_PER_WINDOW; k++)
      push_sample(4095, (k == 0) ? OP_MEASURE : OP_CALIBRATE);
    for (int k = 0; k < SAMPLES_PER_WINDOW; k++)
      push_sample(0, (k == 0) ? OP_MEASURE : logic'($urandom_range(0, 1)));
    drain();

    // uncalibrated: offset register extremes, zero and above-range sensitivity
    run_phase(0, 1, 80, 0);
    run_phase(3300, 100000, 80, 0);
    no_gaps = 1'b1;
    run_phase(4095, 0, 80, 0);
    no_gaps = 1'b0;
    run_phase($urandom_range(0, 3300), 131071, 100, 0);

    // calibrate at full scale, then mixed windows
    reg_write(REG_ZERO_OFFSET, $urandom_range(0, 4095));
    reg_write(REG_SENSITIVITY, pick_sens());
    while (gen_pos != 0)
      push_sample($urandom_range(0, 4095), logic'($urandom_range(0, 1)));
    for (int k = 0; k < SAMPLES_PER_WINDOW; k++)
      push_sample(4095, (k == 0) ? OP_CALIBRATE : OP_MEASURE);
    queue_samples(84, 30);
    drain();

    for (int p = 0; p < 3; p++)
      run_phase($urandom_range(0, 4095), pick_sens(), 100, 30);

    drain();
    errors += expected_readings.size();
    $display("covered %0d samples: %0d measure and %0d calibrate windows, %0d register writes",
             samples_taken, measure_seen, calib_seen, reg_writes);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/acss_pkg.sv
rtl/acss_div.sv
rtl/acss_datapath.sv
rtl/acss_ctrl.sv
rtl/averaged_current_sensor_scaler_top.sv
tb/sv/averaged_current_sensor_scaler_top_test.sv
